// ----- rtl/nalx_pkg.sv -----
// Shared types and constants of the parameter-set group extractor.
package nalx_pkg;

   localparam int unsigned MAX_RESULTS = 5;

   localparam logic [31:0] START_CODE   = 32'h0000_0001;
   localparam logic [2:0]  WINDOW_BYTES = 3'd4;

   localparam logic [4:0] AVC_SPS_TYPE    = 5'd7;
   localparam logic [5:0] HEVC_VPS_TYPE   = 6'd32;
   localparam logic [2:0] AVC_GROUP_NALS  = 3'd3;
   localparam logic [2:0] HEVC_GROUP_NALS = 3'd4;

   localparam logic CODEC_AVC  = 1'b0;
   localparam logic CODEC_HEVC = 1'b1;

   localparam logic STATUS_GROUP    = 1'b0;
   localparam logic STATUS_NO_GROUP = 1'b1;

   localparam logic CFG_CODEC_MODE   = 1'b0;
   localparam logic CFG_START_OFFSET = 1'b1;

   typedef struct packed {
      logic        codec_mode;
      logic [31:0] start_offset;
   } cfg_type;

   // One command per accepted byte: up to five result bytes, oldest first.
   typedef struct packed {
      logic [2:0]                  count;
      logic                        last;
      logic                        status;
      logic [MAX_RESULTS-1:0][7:0] bytes;
   } cmd_type;

endpackage

// ----- rtl/nalx_front.sv -----
// Front end: start-code search, header test and NAL counting per stream byte.
module nalx_front (
   input  logic              clock,
   input  logic              reset,
   input  nalx_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_eod,
   output logic              cmd_valid,
   output nalx_pkg::cmd_type cmd,
   input  logic              cmd_ready
);
   import nalx_pkg::*;

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_EMIT   = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic [3:0][7:0] window_ff, window_in, pushed;
   logic [2:0]      fill_ff, fill_in, fill_inc;
   logic [31:0]     bytes_seen_ff, bytes_seen_in;
   logic [1:0]      phase_ff, phase_in;
   logic            header_next_ff, header_next_in;
   logic [2:0]      nal_count_ff, nal_count_in;

   logic       accept, skip, hdr_match, have_old, is_start, clear;
   logic [2:0] group_nals;

   assign in_ready  = cmd_ready;
   assign accept    = in_valid && cmd_ready;
   assign cmd_valid = accept && (cmd.count != 3'd0);

   assign pushed     = {window_ff[2:0], in_byte};
   assign fill_inc   = (fill_ff < WINDOW_BYTES) ? fill_ff + 3'd1 : fill_ff;
   assign skip       = bytes_seen_ff < cfg.start_offset;
   assign hdr_match  = (cfg.codec_mode == CODEC_HEVC) ? (in_byte[6:1] == HEVC_VPS_TYPE)
                                                      : (in_byte[4:0] == AVC_SPS_TYPE);
   assign group_nals = (cfg.codec_mode == CODEC_HEVC) ? HEVC_GROUP_NALS : AVC_GROUP_NALS;
   assign have_old   = fill_ff >= WINDOW_BYTES;
   assign is_start   = pushed == START_CODE;

   always_comb begin
      window_in      = window_ff;
      fill_in        = fill_ff;
      bytes_seen_in  = (bytes_seen_ff != '1) ? bytes_seen_ff + 32'd1 : bytes_seen_ff;
      phase_in       = phase_ff;
      header_next_in = header_next_ff;
      nal_count_in   = nal_count_ff;
      clear          = 1'b0;
      cmd            = '0;
      cmd.status     = STATUS_GROUP;

      case (phase_ff)
         PH_SEARCH: begin
            if (!skip && header_next_ff && hdr_match) begin
               cmd.bytes[0]   = START_CODE[31:24];
               cmd.bytes[1]   = START_CODE[23:16];
               cmd.bytes[2]   = START_CODE[15:8];
               cmd.bytes[3]   = START_CODE[7:0];
               cmd.count      = 3'd4;
               header_next_in = 1'b0;
               if (in_eod) begin
                  cmd.bytes[4] = in_byte;
                  cmd.count    = 3'd5;
                  cmd.last     = 1'b1;
                  clear        = 1'b1;
               end else begin
                  phase_in     = PH_EMIT;
                  window_in    = {24'd0, in_byte};
                  fill_in      = 3'd1;
                  nal_count_in = 3'd1;
               end
            end else begin
               if (!skip) begin
                  window_in      = pushed;
                  fill_in        = fill_inc;
                  header_next_in = (fill_inc == WINDOW_BYTES) && is_start;
               end
               if (in_eod) begin
                  cmd.count  = 3'd1;
                  cmd.last   = 1'b1;
                  cmd.status = STATUS_NO_GROUP;
                  clear      = 1'b1;
               end
            end
         end
         PH_EMIT: begin
            window_in = pushed;
            fill_in   = fill_inc;
            if (have_old && is_start && (nal_count_ff >= group_nals)) begin
               // The next NAL's start code closes the group and is dropped.
               cmd.bytes[0] = window_ff[3];
               cmd.count    = 3'd1;
               cmd.last     = 1'b1;
               phase_in     = PH_DONE;
               clear        = in_eod;
            end else begin
               if (have_old && is_start) begin
                  nal_count_in = nal_count_ff + 3'd1;
               end
               cmd.bytes[0] = window_ff[3];
               cmd.count    = {2'd0, have_old};
               if (in_eod) begin
                  // End of data mid-group: flush the window, oldest byte first.
                  for (int i = 0; i < 4; i++) begin
                     if (i < int'(fill_inc)) begin
                        cmd.bytes[3'(i) + {2'd0, have_old}] = pushed[2'(fill_inc - 3'd1 - 3'(i))];
                     end
                  end
                  cmd.count = {2'd0, have_old} + fill_inc;
                  cmd.last  = 1'b1;
                  clear     = 1'b1;
               end
            end
         end
         PH_DONE: begin
            clear = in_eod;
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase

      if (clear) begin
         window_in      = '0;
         fill_in        = 3'd0;
         bytes_seen_in  = 32'd0;
         phase_in       = PH_SEARCH;
         header_next_in = 1'b0;
         nal_count_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         fill_ff        <= 3'd0;
         bytes_seen_ff  <= 32'd0;
         phase_ff       <= PH_SEARCH;
         header_next_ff <= 1'b0;
         nal_count_ff   <= 3'd0;
      end else if (accept) begin
         window_ff      <= window_in;
         fill_ff        <= fill_in;
         bytes_seen_ff  <= bytes_seen_in;
         phase_ff       <= phase_in;
         header_next_ff <= header_next_in;
         nal_count_ff   <= nal_count_in;
      end
   end

   // A byte that ends the stream leaves the front in its reset state.
   a_eod_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && in_eod) |=> (phase_ff == PH_SEARCH && bytes_seen_ff == 32'd0
                              && fill_ff == 3'd0 && !header_next_ff))
      else $error("stream state not cleared after end of data");

endmodule

// ----- rtl/nalx_cmd_fifo.sv -----
// Short command queue between the front end and the result sequencer.
module nalx_cmd_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  nalx_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output nalx_pkg::cmd_type pop_data
);
   import nalx_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type [DEPTH-1:0] slots_ff;
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("command queue count beyond depth");

endmodule

// ----- rtl/nalx_back.sv -----
// Result sequencer: plays out the bytes of each queued command, one per cycle while rsp_ready is high.
module nalx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  nalx_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last,
   output logic              rsp_status
);
   import nalx_pkg::*;

   cmd_type    cur_ff;
   logic [2:0] idx_ff;
   logic       busy_ff;
   logic       final_beat, load;

   assign final_beat = idx_ff == (cur_ff.count - 3'd1);
   assign cmd_ready  = !busy_ff || (rsp_ready && final_beat);
   assign load       = cmd_valid && cmd_ready;

   assign rsp_valid  = busy_ff;
   assign rsp_byte   = cur_ff.bytes[idx_ff];
   assign rsp_last   = cur_ff.last && final_beat;
   assign rsp_status = cur_ff.status;

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= 3'd0;
      end else if (busy_ff && rsp_ready) begin
         if (final_beat) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.count != 3'd0 && idx_ff < cur_ff.count))
      else $error("result index outside current command");

endmodule

// ----- rtl/nal_parameter_set_group_extractor.sv -----
// Top level of the parameter-set group extractor for byte streams with start codes.
//
// The block takes a coded video byte stream, one byte per item on req_, skips
// start_offset leading bytes, then hunts for 00 00 00 01 start codes and tests
// the NAL header after each. On the first SPS (codec_mode 0) or VPS
// (codec_mode 1) it sends that NAL and the following two (or three) NALs,
// start codes included, on rsp_, with tlast on the final byte, and then stays
// silent until the byte marked with req_tlast ends the stream. A stream that
// ends mid-group flushes every pending byte; a stream with no group gives a
// single item with tuser set and data zero. The front end takes one byte per
// clock while the command queue has room and turns it into a command of zero
// to five result bytes; a small command queue (CMD_FIFO_DEPTH entries) feeds
// the back end, which sends one result per clock while rsp_tready is high.
// Sustained rate is then one byte per cycle: in the body of a group each byte
// gives one result, so input and output run in lockstep. The start of a group
// gives four results for one byte and an end of data inside a group up to five;
// the queue absorbs them and req_tready drops only while it is full. An
// accepted byte's command is registered in the queue and then in the back end
// before its first result goes out. There is no clearing pass after reset.
// Configuration writes are meant for idle periods between streams.
module nal_parameter_set_group_extractor #(
   parameter int unsigned CMD_FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Stream bytes in.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_data
   // Group bytes out.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // group_last
   output logic        rsp_tuser,   // [0] status
   // Register writes.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import nalx_pkg::*;

   cfg_type cfg_ff;
   cmd_type front_cmd, back_cmd;
   logic    front_valid, front_ready, back_valid, back_ready;

   // Register file: codec selection and the number of bytes to skip.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.codec_mode   <= CODEC_AVC;
         cfg_ff.start_offset <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            CFG_CODEC_MODE:   cfg_ff.codec_mode   <= csr_wdata[0];
            CFG_START_OFFSET: cfg_ff.start_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: window compare, header test and group bookkeeping.
   nalx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_eod    (req_tlast),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   // Decouples byte intake from result delivery.
   nalx_cmd_fifo #(
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   // Back end: one result item per cycle from the queued commands while rsp_tready is high.
   nalx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser)
   );

   // A no-group item is always the only and final item of its stream.
   a_no_group_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_NO_GROUP) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("no-group item without tlast or with nonzero data");

endmodule
